[src/jvm_integer_stack_core_macros.svh]
// Assertion macros for the integer stack core.
`ifndef JVM_INTEGER_STACK_CORE_MACROS_SVH
`define JVM_INTEGER_STACK_CORE_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define JISC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define JISC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[src/jisc_pkg.sv]
// Package: opcodes, status codes, widths and the sequencer state type.
package jisc_pkg;
   localparam int StackDepth = 64;
   localparam int LocalCount = 256;
   localparam int SpW = $clog2(StackDepth + 1);
   localparam int SaW = $clog2(StackDepth);
   localparam int LaW = $clog2(LocalCount);

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_RET = 3'd1;
   localparam logic [2:0] ST_DIVZ = 3'd2;
   localparam logic [2:0] ST_STACK = 3'd3;
   localparam logic [2:0] ST_UNSUP = 3'd4;

   localparam logic [7:0] OP_NOP = 8'h00, OP_ACONST_NULL = 8'h01;
   localparam logic [7:0] OP_ICONST_M1 = 8'h02, OP_ICONST_5 = 8'h08;
   localparam logic [7:0] OP_BIPUSH = 8'h10, OP_SIPUSH = 8'h11;
   localparam logic [7:0] OP_ILOAD = 8'h15, OP_ALOAD = 8'h19;
   localparam logic [7:0] OP_ILOAD_0 = 8'h1a, OP_ILOAD_3 = 8'h1d;
   localparam logic [7:0] OP_ALOAD_0 = 8'h2a, OP_ALOAD_3 = 8'h2d;
   localparam logic [7:0] OP_ISTORE = 8'h36, OP_ASTORE = 8'h3a;
   localparam logic [7:0] OP_ISTORE_0 = 8'h3b, OP_ISTORE_3 = 8'h3e;
   localparam logic [7:0] OP_ASTORE_0 = 8'h4b, OP_ASTORE_3 = 8'h4e;
   localparam logic [7:0] OP_POP = 8'h57, OP_DUP = 8'h59, OP_DUP2 = 8'h5c;
   localparam logic [7:0] OP_SWAP = 8'h5f;
   localparam logic [7:0] OP_IADD = 8'h60, OP_ISUB = 8'h64, OP_IMUL = 8'h68;
   localparam logic [7:0] OP_IDIV = 8'h6c, OP_INEG = 8'h74, OP_IINC = 8'h84;
   localparam logic [7:0] OP_I2C = 8'h92, OP_I2S = 8'h93;
   localparam logic [7:0] OP_IFEQ = 8'h99, OP_IFNE = 8'h9a, OP_IFLT = 8'h9b;
   localparam logic [7:0] OP_IFGE = 8'h9c, OP_IFGT = 8'h9d, OP_IFLE = 8'h9e;
   localparam logic [7:0] OP_ICMPEQ = 8'h9f, OP_ICMPNE = 8'ha0, OP_ICMPLT = 8'ha1;
   localparam logic [7:0] OP_ICMPGE = 8'ha2, OP_ICMPGT = 8'ha3, OP_ICMPLE = 8'ha4;
   localparam logic [7:0] OP_ACMPEQ = 8'ha5, OP_ACMPNE = 8'ha6;
   localparam logic [7:0] OP_GOTO = 8'ha7, OP_ARETURN = 8'hb0, OP_RETURN = 8'hb1;
   localparam logic [7:0] OP_IFNULL = 8'hc6, OP_IFNONNULL = 8'hc7, OP_GOTO_W = 8'hc8;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXEC, S_DIV, S_WB2, S_OUT
   } seq_state_type;

   typedef struct packed {
      logic start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;
endpackage

[src/jisc_stack_ram.sv]
// Operand stack memory: one write port, two registered read ports.
module jisc_stack_ram
   import jisc_pkg::*;
(
   input  logic           clock,
   input  logic           wr_en,
   input  logic [SaW-1:0] wr_addr,
   input  logic [31:0]    wr_data,
   input  logic [SaW-1:0] rd_addr_a,
   input  logic [SaW-1:0] rd_addr_b,
   output logic [31:0]    rd_data_a,
   output logic [31:0]    rd_data_b
);
   logic [31:0] mem [StackDepth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

[src/jisc_local_ram.sv]
// Locals frame memory with per-entry valid bits; invalid entries read as zero.
module jisc_local_ram
   import jisc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  logic [LaW-1:0] wr_addr,
   input  logic [31:0]    wr_data,
   input  logic [LaW-1:0] rd_addr,
   output logic [31:0]    rd_data
);
   logic [31:0]           mem [LocalCount];
   logic [LocalCount-1:0] valid_ff;
   logic [31:0]           raw_ff;
   logic                  hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      raw_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         hit_ff <= valid_ff[rd_addr];
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = hit_ff ? raw_ff : 32'd0;
endmodule

[src/jisc_divider.sv]
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
module jisc_divider
   import jisc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[31]} - {1'b0, den_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         rem_in  = 32'd0;
         quo_in  = req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
         den_in  = req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
         neg_in  = req.dividend[31] ^ req.divisor[31];
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? 32'd0 - quo_ff : quo_ff;
endmodule

[src/jvm_integer_stack_core.sv]
// Top level of the integer stack core: sequencer, pc, stack pointer and result stage.
// Usage:
//   req channel: one beat per fetched instruction. req_tdata carries the opcode
//   in bits 7:0 and the four following bytes in bits 39:8 (first byte in 39:32).
//   rsp channel: one beat per instruction with next pc, stack top, depth and
//   status. Fetch the next instruction at the reported next pc.
// Timing:
//   Every instruction reads the operand stack and locals memories (registered
//   reads), then executes and writes back; the response beat follows in the
//   out state. dup2, swap and a compare that pops two entries and leaves some
//   behind pass a second write-back state first; idiv waits in the bit-serial
//   divider. One instruction is in flight at a time; req_tready is high only
//   in idle, so a new beat waits until the last response is taken.
// Reset: synchronous, active high. Clears pc, stack pointer, halt flag and all
//   locals (through valid bits). Stack contents are undefined until pushed.
// Stall: a pending response holds in the output register until rsp_tready;
//   no new request beat is taken meanwhile.
// After areturn/return the core halts and answers every later beat with
//   status returned and unchanged state.
module jvm_integer_stack_core
   import jisc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // func[7:0], operand_bytes[39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata   // next_pc[15:0], top_value[47:16],
                                   // stack_count[54:48], status[57:55], zero
);
   seq_state_type state_ff, state_in;

   logic [7:0]     op_ff;
   logic [31:0]    ob_ff;
   logic [15:0]    pc_ff, pc_in;
   logic [SpW-1:0] sp_ff, sp_in;
   logic           halt_ff, halt_in;
   logic [15:0]    rpc_ff, rpc_in;
   logic [31:0]    rtop_ff, rtop_in;
   logic [2:0]     rst_ff, rst_in;
   logic [31:0]    top_ff, top_in;   // cached stack top
   logic [31:0]    wb2_ff, wb2_in;   // second push word

   logic           s_we, l_we;
   logic [SaW-1:0] s_waddr, s_ra, s_rb;
   logic [31:0]    s_wdata, s_da, s_db, l_wdata, l_rd;
   logic [LaW-1:0] l_addr;
   div_req_type    dreq;
   logic           d_done;
   logic [31:0]    d_q;

   jisc_stack_ram u_stack (
      .clock, .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr_a(s_ra), .rd_addr_b(s_rb), .rd_data_a(s_da), .rd_data_b(s_db)
   );
   jisc_local_ram u_locals (
      .clock, .reset, .wr_en(l_we), .wr_addr(l_addr), .wr_data(l_wdata),
      .rd_addr(l_addr), .rd_data(l_rd)
   );
   jisc_divider u_div (.clock, .reset, .req(dreq), .done(d_done), .quotient(d_q));

   // Decode fields
   logic [7:0]  b0, b1;
   logic [15:0] off16;
   logic [SpW:0] spx;
   assign b0    = ob_ff[31:24];
   assign b1    = ob_ff[23:16];
   assign off16 = ob_ff[31:16];
   assign spx   = {1'b0, sp_ff};

   function automatic logic room(input logic [SpW:0] sp, input int pops, input int pushes);
      return (sp >= (SpW+1)'(pops)) &&
             (sp - (SpW+1)'(pops) + (SpW+1)'(pushes) <= (SpW+1)'(StackDepth));
   endfunction

   // Memory read addresses: top and second entries; locals at decoded index.
   // During execute, aim port a at the third entry so a two-entry pop finds
   // its new top on the port in the following cycle.
   assign s_ra = (state_ff == S_EXEC) ? SaW'(sp_ff - SpW'(3)) : SaW'(sp_ff - SpW'(1));
   assign s_rb = SaW'(sp_ff - SpW'(2));
   always_comb begin
      case (op_ff)
         OP_ILOAD_0, OP_ILOAD_0+8'd1, OP_ILOAD_0+8'd2, OP_ILOAD_3:
            l_addr = LaW'(op_ff - OP_ILOAD_0);
         OP_ALOAD_0, OP_ALOAD_0+8'd1, OP_ALOAD_0+8'd2, OP_ALOAD_3:
            l_addr = LaW'(op_ff - OP_ALOAD_0);
         OP_ISTORE_0, OP_ISTORE_0+8'd1, OP_ISTORE_0+8'd2, OP_ISTORE_3:
            l_addr = LaW'(op_ff - OP_ISTORE_0);
         OP_ASTORE_0, OP_ASTORE_0+8'd1, OP_ASTORE_0+8'd2, OP_ASTORE_3:
            l_addr = LaW'(op_ff - OP_ASTORE_0);
         default: l_addr = LaW'(b0);
      endcase
   end

   // Execute: combinational over registered memory data in S_EXEC.
   logic [31:0] a, b, res, prod;
   logic [2:0]  xst;
   logic [15:0] xpc;
   logic        xpush, xpush2, xdiv, xsw, xlw, take;
   logic [SpW-1:0] xsp;
   logic [31:0] xlw_data, xtop;
   logic signed [31:0] sa, sb;
   assign b = s_da;
   assign a = s_db;
   assign sa = a;
   assign sb = b;
   assign prod = a * b;

   always_comb begin
      xst = ST_OK; xpc = pc_ff + 16'd1; xsp = sp_ff; xpush = 1'b0; xpush2 = 1'b0;
      xdiv = 1'b0; xlw = 1'b0; xlw_data = l_rd + {{24{b1[7]}}, b1}; res = 32'd0;
      take = 1'b0; xsw = 1'b0;
      case (op_ff)
         OP_NOP: ;
         OP_ACONST_NULL, OP_ICONST_M1, OP_ICONST_M1+8'd1, OP_ICONST_M1+8'd2,
         OP_ICONST_M1+8'd3, OP_ICONST_M1+8'd4, OP_ICONST_M1+8'd5, OP_ICONST_5: begin
            res = 32'(op_ff) - 32'd3;
            if (op_ff == OP_ACONST_NULL) res = 32'd0;
            if (!room(spx, 0, 1)) xst = ST_STACK; else xpush = 1'b1;
         end
         OP_BIPUSH: begin
            res = {{24{b0[7]}}, b0}; xpc = pc_ff + 16'd2;
            if (!room(spx, 0, 1)) xst = ST_STACK; else xpush = 1'b1;
         end
         OP_SIPUSH: begin
            res = {{16{off16[15]}}, off16}; xpc = pc_ff + 16'd3;
            if (!room(spx, 0, 1)) xst = ST_STACK; else xpush = 1'b1;
         end
         OP_ILOAD, OP_ALOAD, OP_ILOAD_0, OP_ILOAD_0+8'd1, OP_ILOAD_0+8'd2, OP_ILOAD_3,
         OP_ALOAD_0, OP_ALOAD_0+8'd1, OP_ALOAD_0+8'd2, OP_ALOAD_3: begin
            res = l_rd;
            if (op_ff == OP_ILOAD || op_ff == OP_ALOAD) xpc = pc_ff + 16'd2;
            if (!room(spx, 0, 1)) xst = ST_STACK; else xpush = 1'b1;
         end
         OP_ISTORE, OP_ASTORE, OP_ISTORE_0, OP_ISTORE_0+8'd1, OP_ISTORE_0+8'd2,
         OP_ISTORE_3, OP_ASTORE_0, OP_ASTORE_0+8'd1, OP_ASTORE_0+8'd2,
         OP_ASTORE_3: begin
            if (op_ff == OP_ISTORE || op_ff == OP_ASTORE) xpc = pc_ff + 16'd2;
            xlw_data = b;
            if (!room(spx, 1, 0)) xst = ST_STACK;
            else begin xlw = 1'b1; xsp = sp_ff - SpW'(1); end
         end
         OP_POP: if (!room(spx, 1, 0)) xst = ST_STACK; else xsp = sp_ff - SpW'(1);
         OP_DUP: begin
            res = b;
            if (!room(spx, 1, 2)) xst = ST_STACK; else xpush = 1'b1;
         end
         OP_DUP2: begin
            res = a;
            if (!room(spx, 2, 4)) xst = ST_STACK; else xpush2 = 1'b1;
         end
         OP_SWAP: begin
            if (!room(spx, 2, 2)) xst = ST_STACK;
            else begin xsw = 1'b1; xsp = sp_ff - SpW'(2); res = b; end
         end
         OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV: begin
            if (op_ff == OP_IADD) res = a + b;
            else if (op_ff == OP_ISUB) res = a - b;
            else res = prod;
            if (!room(spx, 2, 1)) xst = ST_STACK;
            else if (op_ff == OP_IDIV && b == 32'd0) xst = ST_DIVZ;
            else begin
               xsp = sp_ff - SpW'(2);
               if (op_ff == OP_IDIV) xdiv = 1'b1; else xpush = 1'b1;
            end
         end
         OP_INEG, OP_I2C, OP_I2S: begin
            if (op_ff == OP_INEG) res = 32'd0 - b;
            else if (op_ff == OP_I2C) res = {16'd0, b[15:0]};
            else res = {{16{b[15]}}, b[15:0]};
            if (!room(spx, 1, 1)) xst = ST_STACK;
            else begin xsp = sp_ff - SpW'(1); xpush = 1'b1; end
         end
         OP_IINC: begin
            xpc = pc_ff + 16'd3; xlw = 1'b1;
         end
         OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGE, OP_IFGT, OP_IFLE, OP_IFNULL, OP_IFNONNULL: begin
            case (op_ff)
               OP_IFEQ, OP_IFNULL:    take = (b == 32'd0);
               OP_IFNE, OP_IFNONNULL: take = (b != 32'd0);
               OP_IFLT: take = sb < 0;
               OP_IFGE: take = sb >= 0;
               OP_IFGT: take = sb > 0;
               default: take = sb <= 0;
            endcase
            xpc = take ? pc_ff + off16 : pc_ff + 16'd3;
            if (!room(spx, 1, 0)) xst = ST_STACK; else xsp = sp_ff - SpW'(1);
         end
         OP_ICMPEQ, OP_ICMPNE, OP_ICMPLT, OP_ICMPGE, OP_ICMPGT, OP_ICMPLE,
         OP_ACMPEQ, OP_ACMPNE: begin
            case (op_ff)
               OP_ICMPEQ, OP_ACMPEQ: take = (a == b);
               OP_ICMPNE, OP_ACMPNE: take = (a != b);
               OP_ICMPLT: take = sa < sb;
               OP_ICMPGE: take = sa >= sb;
               OP_ICMPGT: take = sa > sb;
               default:   take = sa <= sb;
            endcase
            xpc = take ? pc_ff + off16 : pc_ff + 16'd3;
            if (!room(spx, 2, 0)) xst = ST_STACK; else xsp = sp_ff - SpW'(2);
         end
         OP_GOTO:   xpc = pc_ff + off16;
         OP_GOTO_W: xpc = pc_ff + ob_ff[15:0];
         OP_ARETURN, OP_RETURN: xst = ST_RET;
         default: xst = ST_UNSUP;
      endcase
      if (halt_ff) begin
         xst = ST_RET; xpush = 1'b0; xpush2 = 1'b0; xdiv = 1'b0; xlw = 1'b0;
         xsw = 1'b0; xsp = sp_ff;
      end else if (xst != ST_OK) begin
         xpush = 1'b0; xpush2 = 1'b0; xdiv = 1'b0; xlw = 1'b0; xsw = 1'b0;
         xsp = sp_ff;
      end
      if (xst != ST_OK) xpc = pc_ff;
      // New top after the step, from cached or read values.
      if (xpush) xtop = res;
      else if (xpush2 || xsw) xtop = xsw ? a : b;
      else if (xsp == sp_ff) xtop = top_ff;
      else if (xsp == sp_ff - SpW'(1)) xtop = a;
      else xtop = 32'd0; // refetched below
   end

   // Second-below entry needed when two entries are popped: reread in S_WB2.
   logic need_refetch;
   assign need_refetch = (xsp == sp_ff - SpW'(2)) && !xpush && !xsw && !xdiv &&
                         (xsp != SpW'(0));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_READ;
         S_READ: state_in = S_EXEC;
         S_EXEC: begin
            if (xdiv) state_in = S_DIV;
            else if (xpush2 || xsw || need_refetch) state_in = S_WB2;
            else state_in = S_OUT;
         end
         S_DIV: if (d_done) state_in = S_OUT;
         S_WB2: state_in = S_OUT;
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory writes
   always_comb begin
      pc_in = pc_ff; sp_in = sp_ff; halt_in = halt_ff; rpc_in = rpc_ff;
      rtop_in = rtop_ff; rst_in = rst_ff; top_in = top_ff; wb2_in = wb2_ff;
      s_we = 1'b0; s_waddr = SaW'(sp_ff); s_wdata = res;
      l_we = 1'b0; l_wdata = xlw_data;
      dreq.start = 1'b0; dreq.dividend = a; dreq.divisor = b;
      case (state_ff)
         S_EXEC: begin
            rst_in = xst; rpc_in = xpc; pc_in = xpc; sp_in = xsp;
            if (!halt_ff && (op_ff == OP_ARETURN || op_ff == OP_RETURN)) halt_in = 1'b1;
            if (xlw) l_we = 1'b1;
            if (xpush) begin
               s_we = 1'b1; s_waddr = SaW'(xsp); s_wdata = res;
               sp_in = xsp + SpW'(1);
            end else if (xpush2) begin
               s_we = 1'b1; s_waddr = SaW'(sp_ff); s_wdata = a;
               wb2_in = b;
            end else if (xsw) begin
               s_we = 1'b1; s_waddr = SaW'(xsp); s_wdata = b;
               wb2_in = a;
            end
            dreq.start = xdiv;
            top_in = xtop;
            rtop_in = (sp_in == SpW'(0)) ? 32'd0 : xtop;
         end
         S_DIV: if (d_done) begin
            s_we = 1'b1; s_waddr = SaW'(sp_ff); s_wdata = d_q;
            sp_in = sp_ff + SpW'(1); top_in = d_q; rtop_in = d_q;
         end
         S_WB2: begin
            if (op_ff == OP_DUP2) begin
               s_we = 1'b1; s_waddr = SaW'(sp_ff + SpW'(1)); s_wdata = wb2_ff;
               sp_in = sp_ff + SpW'(2); rtop_in = top_ff;
            end else if (op_ff == OP_SWAP) begin
               s_we = 1'b1; s_waddr = SaW'(sp_ff + SpW'(1)); s_wdata = wb2_ff;
               sp_in = sp_ff + SpW'(2); rtop_in = top_ff;
            end else begin
               // popped two: new top is the entry read at s_ra during execute
               top_in = s_da; rtop_in = s_da;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         op_ff <= req_tdata[7:0];
         ob_ff <= req_tdata[39:8];
      end
      rpc_ff <= rpc_in; rtop_ff <= rtop_in; rst_ff <= rst_in;
      top_ff <= top_in; wb2_ff <= wb2_in;
      if (reset) begin
         state_ff <= S_IDLE; pc_ff <= 16'd0; sp_ff <= '0; halt_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pc_ff <= pc_in; sp_ff <= sp_in; halt_ff <= halt_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {6'd0, rst_ff, 7'(sp_ff), rtop_ff, rpc_ff};

`include "jvm_integer_stack_core_macros.svh"
   `JISC_ASSERT_IMPLY(a_no_overflow, clock, reset, 1'b1, sp_ff <= SpW'(StackDepth), "stack pointer beyond depth")
   `JISC_ASSERT_IMPLY(a_one_owner, clock, reset, 1'b1, !(req_tready && rsp_tvalid), "request taken while response pending")
   `JISC_ASSERT_NEXT(a_halt_sticky, clock, reset, halt_ff, halt_ff, "halt flag cleared")
   `JISC_ASSERT_IMPLY(a_fault_keeps_pc, clock, reset, rsp_tvalid && rst_ff >= ST_DIVZ, rpc_ff == pc_ff, "faulting step moved pc")
endmodule

[dv/tb_jvm_integer_stack_core.sv]
// Self-checking testbench for the integer stack core: directed and random bytecode streams.
module tb_jvm_integer_stack_core;
   import jisc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 5000;   // cycles with no beat on either side
   localparam int RandomItems = 590;

   typedef struct packed {
      logic [7:0]  func;
      logic [31:0] operand_bytes;
   } instr_type;

   // Field order matches rsp_tdata: next_pc in the lowest bits.
   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  stack_count;
      logic [31:0] top_value;
      logic [15:0] next_pc;
   } outcome_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // func[7:0], operand_bytes[39:8]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // next_pc[15:0], top_value[47:16], stack_count[54:48],
                             // status[57:55]

   jvm_integer_stack_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b0; #1;
      clock = 1'b1; #1;
   end

   // Shadow machine state.
   logic [31:0] shadow_stack [StackDepth];
   int unsigned shadow_sp = 0;
   logic [31:0] shadow_locals [LocalCount] = '{default: '0};
   logic [15:0] shadow_pc = '0;
   bit          shadow_halted = 1'b0;

   instr_type   program_q [$];   // instructions not yet taken by the core
   outcome_type outcome_q [$];   // predicted responses still to arrive
   int errors, beats_in, beats_out;
   int status_seen [5];
   int fill_phase_done;

   function automatic bit has_room(int unsigned pops, int unsigned pushes);
      return shadow_sp >= pops && shadow_sp - pops + pushes <= StackDepth;
   endfunction

   function automatic logic [31:0] stack_at(int unsigned k);
      return shadow_stack[shadow_sp - 1 - k];
   endfunction

   function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
      logic [31:0] ua, ub, q;
      ua = a[31] ? -a : a;
      ub = b[31] ? -b : b;
      q = ua / ub;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   // Execute one instruction on the shadow state and return the expected response.
   function automatic outcome_type execute_instr(instr_type ins);
      outcome_type o;
      logic [7:0]  op, b0, b1;
      logic [31:0] ob, a, b, t;
      logic [15:0] npc;
      logic [2:0]  st;
      bit take;
      op = ins.func; ob = ins.operand_bytes;
      b0 = ob[31:24]; b1 = ob[23:16];
      npc = shadow_pc + 16'd1;
      st = ST_OK;
      if (shadow_halted) st = ST_RET;
      else begin
         case (op)
            OP_NOP: ;
            OP_ACONST_NULL, OP_ICONST_M1, OP_ICONST_M1 + 8'd1, OP_ICONST_M1 + 8'd2,
            OP_ICONST_M1 + 8'd3, OP_ICONST_M1 + 8'd4, OP_ICONST_M1 + 8'd5, OP_ICONST_5: begin
               if (!has_room(0, 1)) st = ST_STACK;
               else shadow_stack[shadow_sp++] = (op == OP_ACONST_NULL) ? 32'd0
                                                : 32'(op) - 32'd3;
            end
            OP_BIPUSH: begin
               if (!has_room(0, 1)) st = ST_STACK;
               else shadow_stack[shadow_sp++] = {{24{b0[7]}}, b0};
               npc = shadow_pc + 16'd2;
            end
            OP_SIPUSH: begin
               if (!has_room(0, 1)) st = ST_STACK;
               else shadow_stack[shadow_sp++] = {{16{ob[31]}}, ob[31:16]};
               npc = shadow_pc + 16'd3;
            end
            OP_ILOAD, OP_ALOAD, OP_ILOAD_0, OP_ILOAD_0 + 8'd1, OP_ILOAD_0 + 8'd2, OP_ILOAD_3,
            OP_ALOAD_0, OP_ALOAD_0 + 8'd1, OP_ALOAD_0 + 8'd2, OP_ALOAD_3: begin
               if (op == OP_ILOAD || op == OP_ALOAD) npc = shadow_pc + 16'd2;
               else b0 = (op >= OP_ALOAD_0) ? op - OP_ALOAD_0 : op - OP_ILOAD_0;
               if (!has_room(0, 1)) st = ST_STACK;
               else shadow_stack[shadow_sp++] = shadow_locals[b0];
            end
            OP_ISTORE, OP_ASTORE, OP_ISTORE_0, OP_ISTORE_0 + 8'd1, OP_ISTORE_0 + 8'd2,
            OP_ISTORE_3, OP_ASTORE_0, OP_ASTORE_0 + 8'd1, OP_ASTORE_0 + 8'd2,
            OP_ASTORE_3: begin
               if (op == OP_ISTORE || op == OP_ASTORE) npc = shadow_pc + 16'd2;
               else b0 = (op >= OP_ASTORE_0) ? op - OP_ASTORE_0 : op - OP_ISTORE_0;
               if (!has_room(1, 0)) st = ST_STACK;
               else shadow_locals[b0] = shadow_stack[--shadow_sp];
            end
            OP_POP: if (!has_room(1, 0)) st = ST_STACK; else shadow_sp--;
            OP_DUP: begin
               if (!has_room(1, 2)) st = ST_STACK;
               else begin t = stack_at(0); shadow_stack[shadow_sp++] = t; end
            end
            OP_DUP2: begin
               if (!has_room(2, 4)) st = ST_STACK;
               else begin
                  a = stack_at(1); b = stack_at(0);
                  shadow_stack[shadow_sp++] = a;
                  shadow_stack[shadow_sp++] = b;
               end
            end
            OP_SWAP: begin
               if (!has_room(2, 2)) st = ST_STACK;
               else begin
                  a = stack_at(1); b = stack_at(0);
                  shadow_stack[shadow_sp - 1] = a;
                  shadow_stack[shadow_sp - 2] = b;
               end
            end
            OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV: begin
               if (!has_room(2, 1)) st = ST_STACK;
               else begin
                  b = stack_at(0); a = stack_at(1);
                  if (op == OP_IDIV && b == 32'd0) st = ST_DIVZ;
                  else begin
                     case (op)
                        OP_IADD: t = a + b;
                        OP_ISUB: t = a - b;
                        OP_IMUL: t = a * b;
                        default: t = signed_quotient(a, b);
                     endcase
                     shadow_sp--;
                     shadow_stack[shadow_sp - 1] = t;
                  end
               end
            end
            OP_INEG, OP_I2C, OP_I2S: begin
               if (!has_room(1, 1)) st = ST_STACK;
               else begin
                  t = stack_at(0);
                  if (op == OP_INEG) t = -t;
                  else if (op == OP_I2C) t = {16'd0, t[15:0]};
                  else t = {{16{t[15]}}, t[15:0]};
                  shadow_stack[shadow_sp - 1] = t;
               end
            end
            OP_IINC: begin
               shadow_locals[b0] = shadow_locals[b0] + {{24{b1[7]}}, b1};
               npc = shadow_pc + 16'd3;
            end
            OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGE, OP_IFGT, OP_IFLE, OP_IFNULL, OP_IFNONNULL: begin
               if (!has_room(1, 0)) st = ST_STACK;
               else begin
                  t = shadow_stack[--shadow_sp];
                  case (op)
                     OP_IFEQ, OP_IFNULL: take = (t == 0);
                     OP_IFNE, OP_IFNONNULL: take = (t != 0);
                     OP_IFLT: take = $signed(t) < 0;
                     OP_IFGE: take = $signed(t) >= 0;
                     OP_IFGT: take = $signed(t) > 0;
                     default: take = $signed(t) <= 0;
                  endcase
                  npc = take ? shadow_pc + ob[31:16] : shadow_pc + 16'd3;
               end
            end
            OP_ICMPEQ, OP_ICMPNE, OP_ICMPLT, OP_ICMPGE, OP_ICMPGT, OP_ICMPLE,
            OP_ACMPEQ, OP_ACMPNE: begin
               if (!has_room(2, 0)) st = ST_STACK;
               else begin
                  b = shadow_stack[--shadow_sp];
                  a = shadow_stack[--shadow_sp];
                  case (op)
                     OP_ICMPEQ, OP_ACMPEQ: take = (a == b);
                     OP_ICMPNE, OP_ACMPNE: take = (a != b);
                     OP_ICMPLT: take = $signed(a) < $signed(b);
                     OP_ICMPGE: take = $signed(a) >= $signed(b);
                     OP_ICMPGT: take = $signed(a) > $signed(b);
                     default:   take = $signed(a) <= $signed(b);
                  endcase
                  npc = take ? shadow_pc + ob[31:16] : shadow_pc + 16'd3;
               end
            end
            OP_GOTO: npc = shadow_pc + ob[31:16];
            OP_GOTO_W: npc = shadow_pc + ob[15:0];
            OP_ARETURN, OP_RETURN: begin shadow_halted = 1'b1; st = ST_RET; end
            default: st = ST_UNSUP;
         endcase
      end
      if (st != ST_OK) npc = shadow_pc;
      shadow_pc = npc;
      o.next_pc = npc;
      o.top_value = shadow_sp != 0 ? stack_at(0) : 32'd0;
      o.stack_count = 7'(shadow_sp);
      o.status = st;
      return o;
   endfunction

   // Net depth change of an opcode, used only to steer the generator.
   function automatic int depth_delta(logic [7:0] op);
      case (op)
         OP_ACONST_NULL, OP_BIPUSH, OP_SIPUSH, OP_ILOAD, OP_ALOAD, OP_DUP: return 1;
         OP_POP, OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_ISTORE, OP_ASTORE,
         OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGE, OP_IFGT, OP_IFLE, OP_IFNULL, OP_IFNONNULL:
            return -1;
         OP_ICMPEQ, OP_ICMPNE, OP_ICMPLT, OP_ICMPGE, OP_ICMPGT, OP_ICMPLE,
         OP_ACMPEQ, OP_ACMPNE: return -2;
         OP_DUP2: return 2;
         default: begin
            if (op >= OP_ICONST_M1 && op <= OP_ICONST_5) return 1;
            if (op >= OP_ILOAD_0 && op <= OP_ILOAD_3) return 1;
            if (op >= OP_ALOAD_0 && op <= OP_ALOAD_3) return 1;
            if (op >= OP_ISTORE_0 && op <= OP_ISTORE_3) return -1;
            if (op >= OP_ASTORE_0 && op <= OP_ASTORE_3) return -1;
            return 0;
         end
      endcase
   endfunction

   function automatic instr_type make_instr(logic [7:0] op, logic [31:0] ob);
      instr_type i;
      i.func = op; i.operand_bytes = ob;
      return i;
   endfunction

   // Append one instruction to the pending program.
   function automatic void enqueue_instr(logic [7:0] op, logic [31:0] ob);
      program_q.insert(program_q.size(), make_instr(op, ob));
   endfunction

   // Driver: bursts of beats separated by random gaps.
   int burst_left, gap_left;
   always @(posedge clock) begin
      instr_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            outcome_q.insert(outcome_q.size(), execute_instr(program_q.pop_front()));
            beats_in++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (program_q.size() > 0) begin
               nxt = program_q[0];
               req_tvalid <= 1'b1;
               req_tdata <= {nxt.operand_bytes, nxt.func};
               if (burst_left == 0) begin
                  burst_left = $urandom_range(0, 20);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else burst_left--;
            end else req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: random stall pattern, always-ready stretches and one long hold-off; compare each beat.
   int hold_left;
   bit long_hold_done;
   always @(posedge clock) begin
      outcome_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         long_hold_done = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[57:0];
            beats_out++;
            if (outcome_q.size() == 0) begin
               $display("%0t: response with nothing expected, actual %h", $time, got);
               errors++;
            end else begin
               want = outcome_q.pop_front();
               if (got.status <= ST_UNSUP) status_seen[got.status]++;
               if (got.next_pc !== want.next_pc) begin
                  $display("%0t: next_pc expected %h actual %h", $time, want.next_pc,
                           got.next_pc);
                  errors++;
               end
               if (got.top_value !== want.top_value) begin
                  $display("%0t: top_value expected %h actual %h", $time, want.top_value,
                           got.top_value);
                  errors++;
               end
               if (got.stack_count !== want.stack_count) begin
                  $display("%0t: stack_count expected %0d actual %0d", $time,
                           want.stack_count, got.stack_count);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           got.status);
                  errors++;
               end
            end
            // hold off long once, mid run, while the driver keeps offering
            if (beats_out == 300 && !long_hold_done) begin
               long_hold_done = 1'b1;
               hold_left = 400;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if ((beats_out / 64) % 3 == 1) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 2) != 0);
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   int idle_cycles;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("%0t: timeout, %0d responses outstanding", $time, outcome_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0] pick_ops [$];
      logic [7:0] op;
      int depth, d;
      reset = 1'b1;

      // Directed: underflow, extremes, divide by zero, division overflow, most instruction classes.
      enqueue_instr(OP_POP, 32'h0);
      enqueue_instr(OP_IADD, 32'hffffffff);
      enqueue_instr(OP_SIPUSH, 32'h8000_0000);
      enqueue_instr(OP_DUP, 32'h0);
      enqueue_instr(OP_IMUL, 32'h0);
      enqueue_instr(OP_ICONST_M1 + 8'd3, 32'h0);   // constant two
      enqueue_instr(OP_IMUL, 32'h0);               // -2^31
      enqueue_instr(OP_ICONST_M1, 32'h0);
      enqueue_instr(OP_IDIV, 32'h0);               // overflow case
      enqueue_instr(OP_ICONST_M1 + 8'd1, 32'h0);   // constant zero
      enqueue_instr(OP_IDIV, 32'h0);               // divide by zero
      enqueue_instr(OP_BIPUSH, 32'h80ff_ffff);
      enqueue_instr(OP_ISTORE, 32'hff00_0000);
      enqueue_instr(OP_IINC, 32'hff80_0000);
      enqueue_instr(OP_IINC, 32'hff7f_0000);
      enqueue_instr(OP_ILOAD, 32'hff00_0000);
      enqueue_instr(OP_I2C, 32'h0);
      enqueue_instr(OP_I2S, 32'h0);
      enqueue_instr(OP_INEG, 32'h0);
      enqueue_instr(OP_DUP2, 32'h0);
      enqueue_instr(OP_SWAP, 32'h0);
      enqueue_instr(OP_ICMPGE, 32'h8000_0000);
      enqueue_instr(8'hff, 32'h0);                 // unsupported
      enqueue_instr(OP_GOTO, 32'h7fff_0000);
      enqueue_instr(OP_GOTO_W, 32'hffff_ffff);

      pick_ops = '{OP_NOP, OP_ACONST_NULL, OP_ICONST_M1, OP_ICONST_M1 + 8'd1,
                   OP_ICONST_M1 + 8'd2, OP_ICONST_M1 + 8'd3, OP_ICONST_M1 + 8'd4,
                   OP_ICONST_M1 + 8'd5, OP_ICONST_5, OP_BIPUSH, OP_SIPUSH, OP_ILOAD,
                   OP_ALOAD, OP_ILOAD_0, OP_ILOAD_0 + 8'd1, OP_ILOAD_0 + 8'd2, OP_ILOAD_3,
                   OP_ALOAD_0, OP_ALOAD_0 + 8'd1, OP_ALOAD_0 + 8'd2, OP_ALOAD_3,
                   OP_ISTORE, OP_ASTORE, OP_ISTORE_0, OP_ISTORE_0 + 8'd1,
                   OP_ISTORE_0 + 8'd2, OP_ISTORE_3, OP_ASTORE_0, OP_ASTORE_0 + 8'd1,
                   OP_ASTORE_0 + 8'd2, OP_ASTORE_3, OP_POP, OP_DUP, OP_DUP2, OP_SWAP,
                   OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_INEG, OP_IINC, OP_I2C, OP_I2S,
                   OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGE, OP_IFGT, OP_IFLE, OP_ICMPEQ,
                   OP_ICMPNE, OP_ICMPLT, OP_ICMPGE, OP_ICMPGT, OP_ICMPLE, OP_ACMPEQ,
                   OP_ACMPNE, OP_GOTO, OP_IFNULL, OP_IFNONNULL, OP_GOTO_W};

      // Random: mostly well-formed code that keeps the depth in range, some noise,
      // and one run that pushes past the top of the stack.
      depth = 3;
      fill_phase_done = 0;
      for (int n = 0; n < RandomItems; n++) begin
         if (n == 350 && !fill_phase_done) begin
            fill_phase_done = 1;
            for (int k = 0; k < 70; k++)
               enqueue_instr(OP_BIPUSH, $urandom());
            enqueue_instr(OP_DUP2, 32'h0);
            for (int k = 0; k < 60; k++)
               enqueue_instr(OP_POP, $urandom());
            depth = 4;
         end
         if ($urandom_range(0, 19) == 0) op = 8'($urandom());
         else begin
            op = pick_ops[$urandom_range(0, pick_ops.size() - 1)];
            d = depth_delta(op);
            if (depth + d < 1 && $urandom_range(0, 3) != 0)
               op = OP_BIPUSH;
            else if (depth + d > 40) op = OP_POP;
         end
         d = depth_delta(op);
         if (depth + d >= 0 && depth + d <= StackDepth) depth += d;
         enqueue_instr(op, $urandom());
      end

      // Halt, then confirm the core answers every later beat as returned.
      enqueue_instr(OP_ARETURN, $urandom());
      enqueue_instr(OP_RETURN, $urandom());
      enqueue_instr(OP_ICONST_5, $urandom());
      enqueue_instr(OP_GOTO, $urandom());

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (program_q.size() != 0 || outcome_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Ran %0d instructions, %0d responses checked", beats_in, beats_out);
      $display("Status mix: ok %0d, returned %0d, div0 %0d, stack %0d, unsupported %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4]);
      if (errors == 0 && outcome_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
